// ===== rtl/lrc_pkg.sv =====
`default_nettype none

package lrc_pkg;

  // Built geometry of the store.
  localparam int unsigned DEPTH         = 8;
  localparam int unsigned KEY_BITS      = 32;

  // Widths fixed by the ports.
  localparam int unsigned IN_KEY_BITS   = 32;
  localparam int unsigned STAMP_BITS    = 32;
  localparam int unsigned CAP_BITS      = 4;
  localparam int unsigned SLOT_OUT_BITS = 3;
  localparam int unsigned CAP_RESET     = 8;

  // Derived widths.
  localparam int unsigned SLOT_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_BITS  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_BITS  = (CAP_BITS > OCC_BITS) ? CAP_BITS : OCC_BITS;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [OCC_BITS-1:0]   occ_t;
  typedef logic [CAP_BITS-1:0]   cap_t;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE
  } state_e;

  // One word of the slot memory.
  typedef struct packed {
    key_t   key;
    stamp_t stamp;
  } entry_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic  clear;
    logic  dvalid;
    slot_t didx;
  } scan_ctl_t;

  // Running results of the scan unit.
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    slot_t min_slot;
    key_t  min_key;
  } scan_res_t;

  // Capacity as used: zero counts as one, anything above the built depth saturates.
  function automatic occ_t eff_cap(cap_t cap);
    logic [CMP_BITS-1:0] c;
    c = CMP_BITS'(cap);
    if (c == '0) begin
      c = CMP_BITS'(1);
    end else if (c > CMP_BITS'(DEPTH)) begin
      c = CMP_BITS'(DEPTH);
    end
    return c[OCC_BITS-1:0];
  endfunction

  function automatic key_t in_to_key(logic [IN_KEY_BITS-1:0] k);
    logic [KEY_BITS+IN_KEY_BITS-1:0] w;
    w = {{KEY_BITS{1'b0}}, k};
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [IN_KEY_BITS-1:0] key_to_out(key_t k);
    logic [KEY_BITS+IN_KEY_BITS-1:0] w;
    w = {{IN_KEY_BITS{1'b0}}, k};
    return w[IN_KEY_BITS-1:0];
  endfunction

  function automatic logic [SLOT_OUT_BITS-1:0] slot_to_out(slot_t s);
    logic [SLOT_BITS+SLOT_OUT_BITS-1:0] w;
    w = {{SLOT_OUT_BITS{1'b0}}, s};
    return w[SLOT_OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lru_cache_lookup_replace.sv =====
`default_nettype none

// Fully associative cache of keys with least recently used replacement. Each
// item brings a key; the block reports a hit, a fill of the next free slot, or
// the replacement of the slot with the oldest last-use stamp (ties go to the
// lowest slot), together with the slot number and, on replacement, the key that
// was thrown out. Keys and stamps live in one synchronous memory that is read
// once per occupied slot. On an occupied store the block goes from the idle state
// to the scan state, which reads each occupied slot in turn, then to a tail state
// and a decide state, and loads the result as it leaves the decide state. On an
// empty store it goes from idle straight to decide. The decide state waits while
// a stalled result still sits in the output register. Reads go through the
// memory's single read port. One item is worked on at a time, but the next one is
// taken while a finished result still waits in the output register. The capacity
// register may be written only while the block is idle; zero is treated as one,
// and values above the built depth saturate. Lowering it below the current
// occupancy makes the store count as full without dropping any entry. Stamps
// come from a 32-bit access counter, and the replacement order holds only until
// that counter wraps. The memory needs no clearing after reset: only slots below
// the occupancy are ever read.
module lru_cache_lookup_replace (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Item input
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [31:0] key_i,
  // Result output
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [2:0]  slot_o,
  output logic [31:0] evicted_key_o,
  // Capacity register write
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_data_i
);

  lrc_pkg::state_e state_q, state_d;

  lrc_pkg::key_t   key_q;
  lrc_pkg::occ_t   occ_q, occ_d;
  lrc_pkg::stamp_t cnt_q, cnt_d;
  lrc_pkg::cap_t   cap_q;
  lrc_pkg::slot_t  rd_idx_q, rd_idx_d;
  lrc_pkg::slot_t  ridx_q;
  logic            rvalid_q;

  logic            in_accept;
  logic            rd_en;
  logic            wr_en;
  logic            load_out;
  logic            last_read;
  logic            room;

  lrc_pkg::slot_t     wr_slot;
  lrc_pkg::entry_t    wr_entry;
  lrc_pkg::entry_t    rd_entry;
  lrc_pkg::scan_ctl_t scan_ctl;
  lrc_pkg::scan_res_t scan_res;
  lrc_pkg::outcome_e  outcome;
  lrc_pkg::key_t      evicted;

  logic                   out_valid_q;
  lrc_pkg::outcome_e      outcome_q;
  logic [2:0]             slot_q;
  logic [31:0]            evicted_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != lrc_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // The read address points at the last occupied slot.
  assign last_read = ((lrc_pkg::OCC_BITS'(rd_idx_q) + lrc_pkg::OCC_BITS'(1)) == occ_q);
  assign room      = (occ_q < lrc_pkg::eff_cap(cap_q));

  // Decision on the finished scan.
  always_comb begin
    if (scan_res.hit) begin
      outcome = lrc_pkg::OUT_HIT;
      wr_slot = scan_res.hit_slot;
      evicted = '0;
    end else if (room) begin
      outcome = lrc_pkg::OUT_FILL;
      wr_slot = occ_q[lrc_pkg::SLOT_BITS-1:0];
      evicted = '0;
    end else begin
      outcome = lrc_pkg::OUT_REPLACE;
      wr_slot = scan_res.min_slot;
      evicted = scan_res.min_key;
    end
  end

  assign wr_entry.key   = key_q;
  assign wr_entry.stamp = cnt_q;

  // Sequencer: next state and strobes. The scan unit sees read data in the cycle
  // after the read, tagged with the slot it came from.
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.dvalid = rvalid_q;
    scan_ctl.didx   = ridx_q;
    unique case (state_q)
      lrc_pkg::ST_IDLE: begin
        rd_idx_d = '0;
        if (in_valid_i) begin
          scan_ctl.clear = 1'b1;
          state_d = (occ_q == '0) ? lrc_pkg::ST_DECIDE : lrc_pkg::ST_SCAN;
        end
      end
      lrc_pkg::ST_SCAN: begin
        rd_en    = 1'b1;
        rd_idx_d = rd_idx_q + lrc_pkg::SLOT_BITS'(1);
        if (last_read) begin
          state_d = lrc_pkg::ST_TAIL;
        end
      end
      lrc_pkg::ST_TAIL: begin
        state_d = lrc_pkg::ST_DECIDE;
      end
      lrc_pkg::ST_DECIDE: begin
        if (!out_valid_q || !out_stall_i) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
          state_d  = lrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrc_pkg::ST_IDLE;
      end
    endcase
  end

  // Bookkeeping that the write-back cycle updates.
  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    if (load_out) begin
      cnt_d = cnt_q + lrc_pkg::STAMP_BITS'(1);
      if (outcome == lrc_pkg::OUT_FILL) begin
        occ_d = occ_q + lrc_pkg::OCC_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrc_pkg::ST_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      cap_q       <= lrc_pkg::CAP_BITS'(lrc_pkg::CAP_RESET);
      rd_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      rvalid_q <= rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ridx_q <= rd_idx_q;
    if (in_accept) begin
      key_q <= lrc_pkg::in_to_key(key_i);
    end
    if (load_out) begin
      outcome_q <= outcome;
      slot_q    <= lrc_pkg::slot_to_out(wr_slot);
      evicted_q <= lrc_pkg::key_to_out(evicted);
    end
  end

  lrc_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_slot),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_entry)
  );

  lrc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_q),
    .ctl_i      (scan_ctl),
    .rd_entry_i (rd_entry),
    .res_o      (scan_res)
  );

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign slot_o        = slot_q;
  assign evicted_key_o = evicted_q;

endmodule

`default_nettype wire

// ===== rtl/lrc_store.sv =====
`default_nettype none

// Slot memory: one write port, one read port, registered read data.
module lrc_store (
  input  wire               clk_i,
  input  wire               we_i,
  input  lrc_pkg::slot_t    waddr_i,
  input  lrc_pkg::entry_t   wdata_i,
  input  wire               re_i,
  input  lrc_pkg::slot_t    raddr_i,
  output lrc_pkg::entry_t   rdata_o
);

  lrc_pkg::entry_t mem_q [lrc_pkg::DEPTH];
  lrc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lrc_scan.sv =====
`default_nettype none

// Walks the entries as they come out of the memory: first key match, and the
// oldest stamp with ties going to the lower slot.
module lrc_scan (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lrc_pkg::key_t        key_i,
  input  lrc_pkg::scan_ctl_t   ctl_i,
  input  lrc_pkg::entry_t      rd_entry_i,
  output lrc_pkg::scan_res_t   res_o
);

  logic             hit_q, hit_d;
  lrc_pkg::slot_t   hit_slot_q, hit_slot_d;
  lrc_pkg::slot_t   min_slot_q, min_slot_d;
  lrc_pkg::stamp_t  min_stamp_q, min_stamp_d;
  lrc_pkg::key_t    min_key_q, min_key_d;

  always_comb begin
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    min_slot_d  = min_slot_q;
    min_stamp_d = min_stamp_q;
    min_key_d   = min_key_q;
    if (ctl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctl_i.dvalid) begin
      if (!hit_q && (rd_entry_i.key == key_i)) begin
        hit_d      = 1'b1;
        hit_slot_d = ctl_i.didx;
      end
      if ((ctl_i.didx == '0) || (rd_entry_i.stamp < min_stamp_q)) begin
        min_slot_d  = ctl_i.didx;
        min_stamp_d = rd_entry_i.stamp;
        min_key_d   = rd_entry_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    min_slot_q  <= min_slot_d;
    min_stamp_q <= min_stamp_d;
    min_key_q   <= min_key_d;
  end

  assign res_o.hit      = hit_q;
  assign res_o.hit_slot = hit_slot_q;
  assign res_o.min_slot = min_slot_q;
  assign res_o.min_key  = min_key_q;

endmodule

`default_nettype wire

// ===== rtl/lrc_checker.sv =====
`default_nettype none

module lrc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  outcome_o,
  input wire [2:0]  slot_o,
  input wire [31:0] evicted_key_o
);

  // A result always carries one of the three defined outcomes.
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == lrc_pkg::OUT_HIT || outcome_o == lrc_pkg::OUT_FILL ||
                     outcome_o == lrc_pkg::OUT_REPLACE))
    else $error("result with undefined outcome");

  // Only a replacement reports an evicted key.
  a_evicted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o != lrc_pkg::OUT_REPLACE) |-> (evicted_key_o == 32'd0))
    else $error("evicted key set without a replacement");

  // One item at a time: an accepted item closes the input until it is done.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is still in work");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(outcome_o) && $stable(slot_o) && $stable(evicted_key_o)))
    else $error("stalled result changed");

endmodule

bind lru_cache_lookup_replace lrc_checker u_lrc_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // The run ends early at this many cycles. The slowest correct run is about
  // a thousand items on a full store, plus sender gaps and receiver stalls,
  // the long hold and the settling pauses, and this limit is several times
  // over it.
  localparam int unsigned CYCLE_LIMIT    = 200000;
  // The pause after the last expected result before a capacity write or the
  // end of the run.
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned ITEMS_PER_LOOP = 122;

  // One expected lookup result, in the order in which the block returns them.
  typedef struct {
    lrc_pkg::outcome_e outcome;
    logic [2:0]        slot;
    logic [31:0]       evicted;
  } lookup_result_t;

  // This class holds its own copy of the cache contents and of the capacity
  // register. Each accepted key is run through the replacement policy here,
  // and the expected result is queued until the block returns its result.
  class lru_scoreboard;
    logic [31:0]    slot_key[lrc_pkg::DEPTH];
    logic [31:0]    slot_stamp[lrc_pkg::DEPTH];
    int unsigned    filled;
    logic [31:0]    use_count;
    lrc_pkg::cap_t  capacity;
    lookup_result_t expected_q[$];
    int unsigned    errors;
    int unsigned    n_hit;
    int unsigned    n_fill;
    int unsigned    n_replace;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i]   = '0;
        slot_stamp[i] = '0;
      end
      filled    = 0;
      use_count = '0;
      capacity  = lrc_pkg::cap_t'(lrc_pkg::CAP_RESET);
      errors    = 0;
      n_hit     = 0;
      n_fill    = 0;
      n_replace = 0;
    endfunction

    function void set_capacity(lrc_pkg::cap_t value);
      capacity = value;
    endfunction

    // Zero behaves as one slot, and anything beyond the built depth is clipped.
    function int unsigned usable_slots();
      int unsigned c;
      c = 32'(capacity);
      if (c == 0) begin
        c = 1;
      end
      if (c > lrc_pkg::DEPTH) begin
        c = lrc_pkg::DEPTH;
      end
      return c;
    endfunction

    function void note_key(logic [31:0] key);
      lookup_result_t res;
      bit             found;
      int unsigned    idx;
      found       = 1'b0;
      idx         = 0;
      res.evicted = '0;
      for (int unsigned i = 0; i < filled; i++) begin
        if (!found && slot_key[i] == key) begin
          found = 1'b1;
          idx   = i;
        end
      end
      if (found) begin
        res.outcome     = lrc_pkg::OUT_HIT;
        slot_stamp[idx] = use_count;
      end else if (filled < usable_slots()) begin
        // There is room, so the key takes the next free slot.
        res.outcome     = lrc_pkg::OUT_FILL;
        idx             = filled;
        slot_key[idx]   = key;
        slot_stamp[idx] = use_count;
        filled++;
      end else begin
        // The oldest stamp loses; the strict compare keeps the lowest slot on a tie.
        res.outcome = lrc_pkg::OUT_REPLACE;
        idx         = 0;
        for (int unsigned i = 1; i < filled; i++) begin
          if (slot_stamp[i] < slot_stamp[idx]) begin
            idx = i;
          end
        end
        res.evicted     = slot_key[idx];
        slot_key[idx]   = key;
        slot_stamp[idx] = use_count;
      end
      use_count = use_count + 32'd1;
      res.slot  = idx[2:0];
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_result(logic [1:0] outcome, logic [2:0] slot, logic [31:0] evicted);
      lookup_result_t res;
      if (expected_q.size() == 0) begin
        $error("result with no lookup waiting: outcome %0d slot %0d evicted_key %08h",
               outcome, slot, evicted);
        errors++;
        return;
      end
      res = expected_q.pop_front();
      case (res.outcome)
        lrc_pkg::OUT_HIT:  n_hit++;
        lrc_pkg::OUT_FILL: n_fill++;
        default:           n_replace++;
      endcase
      if (outcome !== res.outcome) begin
        $error("outcome: expected %0d, actual %0d", res.outcome, outcome);
        errors++;
      end
      if (slot !== res.slot) begin
        $error("slot: expected %0d, actual %0d", res.slot, slot);
        errors++;
      end
      if (evicted !== res.evicted) begin
        $error("evicted_key: expected %08h, actual %08h", res.evicted, evicted);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [31:0]   key_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [1:0]    outcome_o;
  logic [2:0]    slot_o;
  logic [31:0]   evicted_key_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  lrc_pkg::cap_t cfg_data_i;

  lru_scoreboard sb;
  int unsigned   cycle_count = 0;
  bit            sender_gaps;
  bit            receiver_gaps;
  bit            hold_request;
  logic [31:0]   key_pool[$];

  lru_cache_lookup_replace i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o),
    .slot_o       (slot_o),
    .evicted_key_o(evicted_key_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Results are taken at the rising edge at which valid is high and the stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(outcome_o, slot_o, evicted_key_o);
    end
  end

  // The result side. It stalls in short random bursts while that is enabled. On
  // request it holds off for one long stretch, counted here, so that the block
  // fills up and stalls its input while the sender carries on offering keys.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i = 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_request = 1'b0;
        out_stall_i  = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Offers one key and returns once it has been accepted. Valid stays high from
  // one item to the next unless a gap is inserted, so back-to-back items never
  // see valid dropped and raised within one time step.
  task automatic push_key(input logic [31:0] key);
    int unsigned gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    key_i      = key;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_key(key);
  endtask

  // Stops offering keys and waits until every lookup has returned and the
  // block has had time to come back to rest.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the capacity register; only ever called while the block is at rest.
  task automatic write_capacity(input lrc_pkg::cap_t value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Most keys come from a small pool so that hits and reuse are common; the
  // rest are fresh random words that force replacements.
  function automatic logic [31:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 99) < 85) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    return $urandom;
  endfunction

  initial begin
    lrc_pkg::cap_t loop_caps[8];
    int unsigned   pool_size;
    sb            = new();
    loop_caps     = '{lrc_pkg::cap_t'(8), lrc_pkg::cap_t'(4), lrc_pkg::cap_t'(9),
                      lrc_pkg::cap_t'(0), lrc_pkg::cap_t'(15), lrc_pkg::cap_t'(6),
                      lrc_pkg::cap_t'(1), lrc_pkg::cap_t'(8)};
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    hold_request  = 1'b0;
    in_valid_i    = 1'b0;
    key_i         = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A capacity of zero acts as a single slot, so the second distinct key
    // already throws the first one out.
    write_capacity(lrc_pkg::cap_t'(0));
    push_key(32'h0000_0000);
    push_key(32'h0000_0000);
    push_key(32'hFFFF_FFFF);
    push_key(32'hFFFF_FFFF);
    push_key(32'h8000_0000);
    settle();

    write_capacity(lrc_pkg::cap_t'(1));
    push_key(32'h0000_0001);
    settle();

    // Three slots: fill two more, touch the oldest entry, then force a
    // replacement of whichever entry is now least recently used.
    write_capacity(lrc_pkg::cap_t'(3));
    push_key(32'h5555_5555);
    push_key(32'hAAAA_AAAA);
    push_key(32'h0000_0001);
    push_key(32'h1234_5678);
    settle();

    // Capacity below the current occupancy: the store counts as full, yet the
    // search and the replacement still cover all three occupied slots.
    write_capacity(lrc_pkg::cap_t'(2));
    push_key(32'hAAAA_AAAA);
    push_key(32'hFFFF_FFFE);
    settle();

    // The largest value saturates at the built depth; fill every slot and
    // replace once more.
    write_capacity(lrc_pkg::cap_t'(15));
    push_key(32'h0000_0002);
    push_key(32'h7FFF_FFFF);
    push_key(32'h0000_0003);
    push_key(32'hC3C3_C3C3);
    push_key(32'h3C3C_3C3C);
    push_key(32'h0F0F_0F0F);
    push_key(32'hFFFF_FFFE);
    settle();

    // Random part, in loops separated by capacity writes. In the third loop the
    // receiver holds off for a long while; the last loop runs without idling.
    for (int unsigned lp = 0; lp < 8; lp++) begin
      write_capacity(loop_caps[lp]);
      sender_gaps   = (lp != 7);
      receiver_gaps = (lp != 7);
      if (lp == 2) begin
        hold_request = 1'b1;
      end
      key_pool.delete();
      pool_size = $urandom_range(4, 16);
      for (int unsigned i = 0; i < pool_size; i++) begin
        key_pool.insert(key_pool.size(), $urandom);
      end
      for (int unsigned n = 0; n < ITEMS_PER_LOOP; n++) begin
        push_key(pick_key());
      end
      settle();
    end

    $display("Checked %0d lookups: %0d hits, %0d fills, %0d replacements.",
             sb.n_hit + sb.n_fill + sb.n_replace, sb.n_hit, sb.n_fill, sb.n_replace);
    $display("Capacity ran through zero, one, reduced below occupancy, mid values and saturation.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
